[hdl/bnc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// bnc_pkg: constants, types and the bracket decoder of the bracket nesting checker
// no dependencies

package bnc_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int SCORE_W         = 38;
    localparam int CH_W            = 8;
    localparam int STATUS_W        = 2;
    localparam int KIND_W          = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_MISMATCH  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    localparam logic [KIND_W-1:0] KIND_PAREN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CURLY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ANGLE = 2'd3;

    localparam logic [CH_W-1:0] CH_OPEN_PAREN   = 8'h28;
    localparam logic [CH_W-1:0] CH_CLOSE_PAREN  = 8'h29;
    localparam logic [CH_W-1:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [CH_W-1:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [CH_W-1:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [CH_W-1:0] CH_CLOSE_CURLY  = 8'h7D;
    localparam logic [CH_W-1:0] CH_OPEN_ANGLE   = 8'h3C;
    localparam logic [CH_W-1:0] CH_CLOSE_ANGLE  = 8'h3E;

    typedef struct packed {
        logic              is_bracket;
        logic              closer;
        logic [KIND_W-1:0] kind;
    } t_bracket;

    function automatic t_bracket decode_bracket(input logic [CH_W-1:0] ch);
        t_bracket b;
        b = '{is_bracket: 1'b1, closer: 1'b0, kind: KIND_PAREN};
        case (ch)
            CH_OPEN_PAREN:   b.kind = KIND_PAREN;
            CH_OPEN_SQUARE:  b.kind = KIND_SQUARE;
            CH_OPEN_CURLY:   b.kind = KIND_CURLY;
            CH_OPEN_ANGLE:   b.kind = KIND_ANGLE;
            CH_CLOSE_PAREN:  begin b.closer = 1'b1; b.kind = KIND_PAREN;  end
            CH_CLOSE_SQUARE: begin b.closer = 1'b1; b.kind = KIND_SQUARE; end
            CH_CLOSE_CURLY:  begin b.closer = 1'b1; b.kind = KIND_CURLY;  end
            CH_CLOSE_ANGLE:  begin b.closer = 1'b1; b.kind = KIND_ANGLE;  end
            default:         b.is_bracket = 1'b0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

[hdl/bracket_nesting_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// bracket_nesting_checker: per-line bracket nesting check with completion score
// depends on bnc_pkg
//
// Input channel (i_in_valid / o_in_ready) takes one byte per transaction, with
// i_line_end high on the last byte of a line. Output channel (o_out_valid /
// i_out_ready) gives one transaction per line: o_status and o_score.
// The open-bracket stack lives in a single-port-write, registered-read memory
// of STACK_DEPTH entries. An opener or a non-bracket byte is handled in S_IDLE;
// a closer also passes through S_CMP (read the top entry, then compare). On
// the last byte the stack is walked top down through the same read port, with
// S_WALK reading and S_ACC adding each entry, then S_DONE loading the result.
// Bytes are not taken during a closer compare, a score walk or S_DONE.
// A finished result sits in the output register; the next line's bytes are
// taken while it waits, and only the next line's result stalls behind it.
// Reset clears the stack count, error and output valid; memory contents are
// not cleared and need no clearing pass.

module bracket_nesting_checker
    import bnc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [CH_W-1:0]     i_ch,
    input  wire logic                i_line_end,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [STATUS_W-1:0]      o_status,
    output logic [SCORE_W-1:0]       o_score
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CMP  = 5'b00010,
        S_WALK = 5'b00100,
        S_ACC  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    logic [KIND_W-1:0] mem [STACK_DEPTH];

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    t_status               r_err, n_err;
    logic                  r_last, n_last;
    logic [KIND_W-1:0]     r_kind, n_kind;
    logic [SCORE_W-1:0]    r_score, n_score;
    logic                  r_out_valid, n_out_valid;
    t_status               r_out_status, n_out_status;
    logic [SCORE_W-1:0]    r_out_score, n_out_score;
    logic [KIND_W-1:0]     r_rd_data;

    logic                  w_wr_en;
    logic [AW-1:0]         w_wr_addr;
    logic [KIND_W-1:0]     w_wr_data;
    logic [AW-1:0]         w_rd_addr;
    logic [CW-1:0]         w_count_m1;
    logic                  w_accept;
    t_bracket              w_br;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_score     = r_out_score;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_br       = decode_bracket(i_ch);
    assign w_count_m1 = r_count - CW'(1);
    assign w_rd_addr  = w_count_m1[AW-1:0];
    assign w_wr_addr  = r_count[AW-1:0];
    assign w_wr_data  = w_br.kind;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_err        = r_err;
        n_last       = r_last;
        n_kind       = r_kind;
        n_score      = r_score;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_score  = r_out_score;
        w_wr_en      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_last  = i_line_end;
                    n_kind  = w_br.kind;
                    n_state = i_line_end ? S_WALK : S_IDLE;
                    if (r_err == ST_OK && w_br.is_bracket) begin
                        if (!w_br.closer) begin
                            if (r_count >= FULL_COUNT) begin
                                n_err = ST_OVERFLOW;
                            end else begin
                                w_wr_en = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end else if (r_count == '0) begin
                            n_err = ST_UNDERFLOW;
                        end else begin
                            // top entry read is in flight
                            n_state = S_CMP;
                        end
                    end
                end
            end
            S_CMP: begin
                if (r_rd_data == r_kind) begin
                    n_count = w_count_m1;
                end else begin
                    n_err = ST_MISMATCH;
                end
                n_state = r_last ? S_WALK : S_IDLE;
            end
            S_WALK: begin
                if (r_err != ST_OK || r_count == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_score = (r_score << 2) + r_score + SCORE_W'(r_rd_data) + SCORE_W'(1);
                n_count = w_count_m1;
                n_state = S_WALK;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_err;
                    n_out_score  = r_score;
                    n_err        = ST_OK;
                    n_count      = '0;
                    n_score      = '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_err       <= ST_OK;
            r_score     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_err       <= n_err;
            r_score     <= n_score;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last       <= n_last;
        r_kind       <= n_kind;
        r_out_status <= n_out_status;
        r_out_score  <= n_out_score;
    end

    // stack memory
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= mem[w_rd_addr];
    end

endmodule

`default_nettype wire

[test/tb_bracket_nesting_checker.sv]
`timescale 1ns / 1ps
// tb_bracket_nesting_checker: self-checking testbench for the bracket nesting checker
// depends on bnc_pkg and bracket_nesting_checker

module tb_bracket_nesting_checker;
    import bnc_pkg::*;

    localparam int DEPTH        = STACK_DEPTH_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
    localparam int HOLD_CYCLES  = 400;

    typedef enum int {
        LINE_CLEAN,
        LINE_DEEP,
        LINE_FAULTY,
        LINE_OVERFLOW,
        LINE_FULL_ANGLE,
        LINE_NOISE
    } t_line_flavor;

    typedef struct {
        t_status             status;
        logic [SCORE_W-1:0]  score;
    } t_line_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [CH_W-1:0]      i_ch = '0;
    logic                 i_line_end = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [STATUS_W-1:0]  o_status;
    logic [SCORE_W-1:0]   o_score;

    logic [CH_W-1:0] open_ch [4] = '{CH_OPEN_PAREN, CH_OPEN_SQUARE, CH_OPEN_CURLY,
                                     CH_OPEN_ANGLE};
    logic [CH_W-1:0] close_ch [4] = '{CH_CLOSE_PAREN, CH_CLOSE_SQUARE, CH_CLOSE_CURLY,
                                      CH_CLOSE_ANGLE};

    // expected nesting state of the current line
    logic [KIND_W-1:0] nest_kind [DEPTH];
    int                nest_depth = 0;
    t_status           line_status = ST_OK;
    t_line_result      line_results_q[$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_req = 1'b0;
    logic hold_out = 1'b0;
    int  bytes_sent = 0;
    int  lines_sent = 0;
    int  fail_count = 0;
    int  cycle_count = 0;
    int  status_count [4] = '{0, 0, 0, 0};

    bracket_nesting_checker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_ch        (i_ch),
        .i_line_end  (i_line_end),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_score     (o_score)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("bracket_nesting_checker regression: fail");
            $finish;
        end
    end

    // bracket kind of a byte, -1 for any other byte
    function automatic int bracket_kind(input logic [CH_W-1:0] ch, output bit closing);
        closing = 1'b0;
        case (ch)
            CH_OPEN_PAREN:   return KIND_PAREN;
            CH_OPEN_SQUARE:  return KIND_SQUARE;
            CH_OPEN_CURLY:   return KIND_CURLY;
            CH_OPEN_ANGLE:   return KIND_ANGLE;
            CH_CLOSE_PAREN:  begin closing = 1'b1; return KIND_PAREN;  end
            CH_CLOSE_SQUARE: begin closing = 1'b1; return KIND_SQUARE; end
            CH_CLOSE_CURLY:  begin closing = 1'b1; return KIND_CURLY;  end
            CH_CLOSE_ANGLE:  begin closing = 1'b1; return KIND_ANGLE;  end
            default:         return -1;
        endcase
    endfunction

    task automatic track_byte(input logic [CH_W-1:0] ch, input logic last);
        bit           closing;
        int           k;
        logic [63:0]  acc;
        t_line_result res;
        if (line_status == ST_OK) begin
            k = bracket_kind(ch, closing);
            if (k >= 0) begin
                if (!closing) begin
                    if (nest_depth >= DEPTH) begin
                        line_status = ST_OVERFLOW;
                    end else begin
                        nest_kind[nest_depth] = k[KIND_W-1:0];
                        nest_depth++;
                    end
                end else if (nest_depth == 0) begin
                    line_status = ST_UNDERFLOW;
                end else if (nest_kind[nest_depth-1] == k[KIND_W-1:0]) begin
                    nest_depth--;
                end else begin
                    line_status = ST_MISMATCH;
                end
            end
        end
        if (last) begin
            acc = '0;
            if (line_status == ST_OK) begin
                for (int i = nest_depth - 1; i >= 0; i--)
                    acc = acc * 5 + nest_kind[i] + 1;
            end
            res.status = line_status;
            res.score  = acc[SCORE_W-1:0];
            line_results_q = {line_results_q, res};
            nest_depth  = 0;
            line_status = ST_OK;
            lines_sent++;
        end
    endtask

    task automatic send_byte(input logic [CH_W-1:0] ch, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ch       <= ch;
        i_line_end <= last;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
        track_byte(ch, last);
        bytes_sent++;
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (line_results_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("mismatch at result %0d: %s: expected %0d, got %0d",
                 lines_sent - line_results_q.size(), what, want, got);
        fail_count++;
    endtask

    function automatic logic [CH_W-1:0] noise_char();
        logic [CH_W-1:0] c;
        bit              closing;
        do c = 8'($urandom_range(255)); while (bracket_kind(c, closing) >= 0);
        return c;
    endfunction

    function automatic logic [CH_W-1:0] next_char(input t_line_flavor flavor);
        int r;
        r = $urandom_range(99);
        case (flavor)
            LINE_NOISE:      return 8'($urandom_range(255));
            LINE_OVERFLOW:   return open_ch[$urandom_range(3)];
            LINE_FULL_ANGLE: return CH_OPEN_ANGLE;
            LINE_DEEP: begin
                if (nest_depth >= DEPTH)
                    return noise_char();
                return (r < 30) ? CH_OPEN_ANGLE : open_ch[$urandom_range(3)];
            end
            default: begin
                if (flavor == LINE_FAULTY && r < 15)
                    return close_ch[$urandom_range(3)];
                if (r < 20)
                    return noise_char();
                if (nest_depth > 0 && (r < 60 || nest_depth >= DEPTH))
                    return close_ch[nest_kind[nest_depth-1]];
                return open_ch[$urandom_range(3)];
            end
        endcase
    endfunction

    task automatic send_line(input t_line_flavor flavor, input int len);
        for (int i = 0; i < len; i++)
            send_byte(next_char(flavor), i == len - 1);
    endtask

    // receiver side
    always @(posedge i_clk)
        i_out_ready <= !hold_out && ($urandom_range(99) >= recv_idle_pct);

    initial begin
        forever begin
            wait (hold_req);
            @(posedge i_clk);
            hold_out <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_out <= 1'b0;
            hold_req = 1'b0;
        end
    end

    always @(negedge i_clk) begin : check_results
        t_line_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (line_results_q.size() == 0) begin
                report_mismatch("result with none expected", 0, o_status);
            end else begin
                want = line_results_q.pop_front();
                status_count[want.status]++;
                if (o_status !== want.status)
                    report_mismatch("status", want.status, o_status);
                if (o_score !== want.score)
                    report_mismatch("score", want.score, o_score);
            end
        end
    end

    task automatic test_basic_nesting();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_byte(CH_OPEN_PAREN, 1'b0);
        send_byte(CH_OPEN_SQUARE, 1'b0);
        send_byte(CH_OPEN_CURLY, 1'b0);
        send_byte(CH_OPEN_ANGLE, 1'b1);
        send_byte(8'h00, 1'b1);
        wait_drain();
    endtask

    task automatic test_error_cases();
        send_byte(CH_CLOSE_PAREN, 1'b1);
        // mismatch, then a closer that must be ignored
        send_byte(CH_OPEN_PAREN, 1'b0);
        send_byte(CH_CLOSE_SQUARE, 1'b0);
        send_byte(CH_CLOSE_PAREN, 1'b0);
        send_byte(8'hFF, 1'b1);
        wait_drain();
    endtask

    task automatic test_overflow();
        for (int i = 0; i <= DEPTH; i++)
            send_byte(CH_OPEN_ANGLE, i == DEPTH);
        wait_drain();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int n_bytes);
        int           start;
        int           len;
        int           r;
        t_line_flavor flavor;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            r = $urandom_range(99);
            if (r < 55) begin
                flavor = LINE_CLEAN;
                len = $urandom_range(1, 14);
            end else if (r < 65) begin
                flavor = LINE_DEEP;
                len = $urandom_range(12, 24);
            end else if (r < 80) begin
                flavor = LINE_FAULTY;
                len = $urandom_range(2, 12);
            end else if (r < 86) begin
                flavor = LINE_OVERFLOW;
                len = $urandom_range(DEPTH + 1, DEPTH + 4);
            end else if (r < 89) begin
                flavor = LINE_FULL_ANGLE;
                len = DEPTH;
            end else begin
                flavor = LINE_NOISE;
                len = $urandom_range(1, 8);
            end
            send_line(flavor, len);
        end
        wait_drain();
    endtask

    task automatic test_output_stall();
        int start;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        start = bytes_sent;
        while (bytes_sent - start < 100)
            send_line(LINE_CLEAN, $urandom_range(1, 4));
        wait_drain();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_nesting();
        test_error_cases();
        test_overflow();
        test_random_traffic(32, 68, 400);
        test_random_traffic(68, 32, 400);
        test_random_traffic(0, 0, 400);
        test_output_stall();

        $display("covered %0d bytes in %0d lines, with a %0d-cycle output stall",
                 bytes_sent, lines_sent, HOLD_CYCLES);
        $display("line outcomes: ok %0d, mismatch %0d, empty-stack close %0d, overflow %0d",
                 status_count[ST_OK], status_count[ST_MISMATCH],
                 status_count[ST_UNDERFLOW], status_count[ST_OVERFLOW]);
        if (fail_count == 0) begin
            $display("bracket_nesting_checker regression: pass");
        end else begin
            $display("bracket_nesting_checker regression: fail");
        end
        $finish;
    end

endmodule
